>>> design/ilp_pkg.sv
// Shared types, constants and a helper function for the integer literal parser.
package ilp_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OUT_WIDTH = 32;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FORMAT   = 2'd1;
	localparam logic [1:0] ST_NUMBER   = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// Radix codes.
	localparam logic [1:0] RDX_DEC = 2'd0;
	localparam logic [1:0] RDX_HEX = 2'd1;
	localparam logic [1:0] RDX_OCT = 2'd2;
	localparam logic [1:0] RDX_BIN = 2'd3;

	// Position codes.
	localparam logic [1:0] POS_NONE  = 2'd0;
	localparam logic [1:0] POS_SIGN  = 2'd1;
	localparam logic [1:0] POS_ONE   = 2'd2;
	localparam logic [1:0] POS_MORE  = 2'd3;

	// Characters of interest.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_B     = 8'h62;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} chr_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] value;
		logic [1:0]                  status;
	} res_t;

	typedef struct packed {
		logic [1:0] radix_code;
		logic       negative;
		logic [1:0] position;
		logic       previous_was_digit;
		logic       first_was_zero;
		logic [1:0] error_code;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{
		radix_code: RDX_DEC,
		negative: 1'b0,
		position: POS_NONE,
		previous_was_digit: 1'b0,
		first_was_zero: 1'b0,
		error_code: ST_OK
	};

	// Bit 4 set means the character is no hex digit; bits 3:0 hold the digit value.
	function automatic logic [4:0] digit_of(input logic [7:0] ch);
		logic [4:0] d;
		d = 5'h10;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			d = {1'b0, 4'(ch - CH_ZERO)};
		end else if (ch >= CH_LA && ch <= CH_LF) begin
			d = {1'b0, 4'(ch - CH_LA + 8'd10)};
		end else if (ch >= CH_UA && ch <= CH_UF) begin
			d = {1'b0, 4'(ch - CH_UA + 8'd10)};
		end
		return d;
	endfunction

endpackage

>>> design/ilp_step.sv
// Combinational single-character step: next parser state and the result of a final character.
module ilp_step #(
	parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
	input  ilp_pkg::ctl_t           ctl,
	input  logic [VALUE_WIDTH-2:0]  acc,
	input  logic [7:0]              ch,
	input  logic                    fin,
	output ilp_pkg::ctl_t           ctl_next,
	output logic [VALUE_WIDTH-2:0]  acc_next,
	output ilp_pkg::res_t           res
);

	localparam int AW = VALUE_WIDTH - 1;
	localparam int PW = AW + 5;
	localparam int EW = (VALUE_WIDTH > ilp_pkg::OUT_WIDTH) ? VALUE_WIDTH : ilp_pkg::OUT_WIDTH;

	logic [4:0]    dig;
	logic          dig_bad;
	logic [PW-1:0] acc_ext;
	logic [PW-1:0] scaled;
	logic [PW-1:0] sum;
	logic          over;
	logic          body0;
	logic          body1;
	logic          is_prefix;
	logic [1:0]    status;
	logic [EW-1:0] mag;
	logic [EW-1:0] signed_val;

	assign dig     = ilp_pkg::digit_of(ch);
	assign acc_ext = PW'(acc);

	always_comb begin
		unique case (ctl.radix_code)
			ilp_pkg::RDX_HEX: begin
				scaled  = acc_ext << 4;
				dig_bad = dig[4];
			end
			ilp_pkg::RDX_OCT: begin
				scaled  = acc_ext << 3;
				dig_bad = dig[4] || dig[3];
			end
			ilp_pkg::RDX_BIN: begin
				scaled  = acc_ext << 1;
				dig_bad = dig[4] || (dig[3:1] != 3'd0);
			end
			default: begin
				scaled  = (acc_ext << 3) + (acc_ext << 1);
				dig_bad = dig[4] || (dig[3:0] > 4'd9);
			end
		endcase
	end

	// The new magnitude overflows when any bit at or above the sign position is set.
	assign sum  = scaled + PW'(dig[3:0]);
	assign over = (sum[PW-1:AW] != '0);

	assign body0     = (ctl.position == ilp_pkg::POS_NONE) || (ctl.position == ilp_pkg::POS_SIGN);
	assign body1     = (ctl.position == ilp_pkg::POS_ONE);
	assign is_prefix = body1 && ctl.first_was_zero && !fin &&
		(ch == ilp_pkg::CH_X || ch == ilp_pkg::CH_O || ch == ilp_pkg::CH_B);

	always_comb begin
		ctl_next = ctl;
		acc_next = acc;
		if (ctl.error_code == ilp_pkg::ST_OK) begin
			if (ctl.position == ilp_pkg::POS_NONE &&
				(ch == ilp_pkg::CH_PLUS || ch == ilp_pkg::CH_MINUS)) begin
				ctl_next.negative = (ch == ilp_pkg::CH_MINUS);
				ctl_next.position = ilp_pkg::POS_SIGN;
			end else begin
				ctl_next.position = body0 ? ilp_pkg::POS_ONE : ilp_pkg::POS_MORE;
				if (is_prefix) begin
					if (ch == ilp_pkg::CH_X) begin
						ctl_next.radix_code = ilp_pkg::RDX_HEX;
					end else if (ch == ilp_pkg::CH_O) begin
						ctl_next.radix_code = ilp_pkg::RDX_OCT;
					end else begin
						ctl_next.radix_code = ilp_pkg::RDX_BIN;
					end
					acc_next = '0;
					ctl_next.previous_was_digit = 1'b0;
				end else begin
					if (body0) begin
						ctl_next.first_was_zero = (ch == ilp_pkg::CH_ZERO);
					end
					if (ch == ilp_pkg::CH_UNDER) begin
						if (!ctl.previous_was_digit) begin
							ctl_next.error_code = ilp_pkg::ST_FORMAT;
						end
						ctl_next.previous_was_digit = 1'b0;
					end else begin
						ctl_next.previous_was_digit = 1'b1;
						if (dig_bad) begin
							ctl_next.error_code = ilp_pkg::ST_NUMBER;
						end else if (over) begin
							ctl_next.error_code = ilp_pkg::ST_OVERFLOW;
						end else begin
							acc_next = sum[AW-1:0];
						end
					end
				end
			end
		end
	end

	always_comb begin
		status = ctl_next.error_code;
		if (status == ilp_pkg::ST_OK) begin
			if (ctl_next.position == ilp_pkg::POS_NONE ||
				ctl_next.position == ilp_pkg::POS_SIGN) begin
				status = ilp_pkg::ST_FORMAT;
			end else if (!ctl_next.previous_was_digit) begin
				status = ilp_pkg::ST_NUMBER;
			end
		end
	end

	assign mag        = EW'(acc_next);
	assign signed_val = ctl_next.negative ? (EW'(0) - mag) : mag;

	assign res.status = status;
	assign res.value  = (status == ilp_pkg::ST_OK) ? signed_val[ilp_pkg::OUT_WIDTH-1:0] : '0;

endmodule

>>> design/integer_literal_parser.sv
// Top level of the integer literal parser: input register, parser state and result register.
// A final character is held in the input register and its result is then registered in the result register.
// Throughput: one character per cycle unless a final character waits; the accumulate step loops on the state.
// A final character waits in the input register only while an earlier result is not taken.
// Reset (arst_n low) empties both registers and returns the parser to the start of a literal.
// After reset chr_ready is high, so the block takes characters straight away.
module integer_literal_parser #(
	parameter int VALUE_WIDTH = ilp_pkg::VALUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          chr_valid,
	output logic          chr_ready,
	input  ilp_pkg::chr_t chr_data,
	output logic          res_valid,
	input  logic          res_ready,
	output ilp_pkg::res_t res_data
);

	logic                   valid_s1;
	ilp_pkg::chr_t          data_s1;
	ilp_pkg::ctl_t          ctl_q;
	logic [VALUE_WIDTH-2:0] acc_q;
	logic                   res_valid_q;
	ilp_pkg::res_t          res_data_q;

	ilp_pkg::ctl_t          ctl_next;
	logic [VALUE_WIDTH-2:0] acc_next;
	ilp_pkg::res_t          step_res;
	logic                   advance;

	ilp_step #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.ctl(ctl_q),
		.acc(acc_q),
		.ch(data_s1.ch),
		.fin(data_s1.last),
		.ctl_next(ctl_next),
		.acc_next(acc_next),
		.res(step_res)
	);

	// A final character may only move on when the result register is free or being emptied.
	assign advance   = valid_s1 && (!data_s1.last || !res_valid_q || res_ready);
	assign chr_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr_ready) begin
			valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_ready) begin
			data_s1 <= chr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= ilp_pkg::CTL_RESET;
			acc_q <= '0;
		end else if (advance) begin
			if (data_s1.last) begin
				ctl_q <= ilp_pkg::CTL_RESET;
				acc_q <= '0;
			end else begin
				ctl_q <= ctl_next;
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && data_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && data_s1.last) begin
			res_data_q <= step_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

>>> design/ilp_checker.sv
// Port-level checks for the integer literal parser, bound to the top level.
module ilp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          chr_valid,
	input logic          chr_ready,
	input ilp_pkg::chr_t chr_data,
	input logic          res_valid,
	input logic          res_ready,
	input ilp_pkg::res_t res_data
);

	// Final characters transferred in whose results have not yet been transferred out.
	logic [2:0] pending_q;
	logic       fin_in;
	logic       res_out;

	assign fin_in  = chr_valid && chr_ready && chr_data.last;
	assign res_out = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(fin_in) - 3'(res_out);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed or dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ilp_pkg::ST_OK |-> res_data.value == '0)
		else $error("non-zero value with an error status");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 3'd0)
		else $error("result without a final character");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more literals in flight than the pipeline holds");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chr_ready |-> res_valid && !res_ready)
		else $error("input stalled without a stalled result");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the integer literal parser: directed and random literals.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned MAX_MAGNITUDE =
		(64'd1 << (ilp_pkg::VALUE_WIDTH_DEF - 1)) - 64'd1;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_CHARS = 420;

	logic clk = 1'b0;
	logic arst_n;
	logic chr_valid;
	logic chr_ready;
	ilp_pkg::chr_t chr_data;
	logic res_valid;
	logic res_ready;
	ilp_pkg::res_t res_data;

	// Parser state as the predictor sees it.
	logic [63:0] lit_acc;
	logic [1:0] lit_radix;
	logic lit_negative;
	logic [1:0] lit_pos;
	logic lit_prev_digit;
	logic lit_first_zero;
	logic [1:0] lit_error;

	ilp_pkg::res_t parsed_values[$];
	logic [7:0] lit_chars[$];
	int error_count = 0;
	int idle_cycles = 0;
	logic no_idle = 1'b0;

	string boundary_lits[0:9] = '{"2147483647", "-2147483647", "2147483648", "-2147483648",
		"+0x7FFFFFFF", "0x80000000", "-0o17777777777", "0o20000000000", "0", "-0"};

	integer_literal_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.chr_valid(chr_valid),
		.chr_ready(chr_ready),
		.chr_data(chr_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic add_char(input logic [7:0] c);
		lit_chars = {lit_chars, c};
	endtask

	task automatic clear_literal();
		lit_acc = '0;
		lit_radix = ilp_pkg::RDX_DEC;
		lit_negative = 1'b0;
		lit_pos = ilp_pkg::POS_NONE;
		lit_prev_digit = 1'b0;
		lit_first_zero = 1'b0;
		lit_error = ilp_pkg::ST_OK;
	endtask

	// Advances the predicted parser by one character and queues the value on the final one.
	task automatic parse_char(input logic [7:0] c, input logic fin);
		logic body_first;
		logic body_second;
		int d;
		int rad;
		logic [63:0] full;
		ilp_pkg::res_t want;
		if (lit_error == ilp_pkg::ST_OK) begin
			if (lit_pos == ilp_pkg::POS_NONE &&
					(c == ilp_pkg::CH_PLUS || c == ilp_pkg::CH_MINUS)) begin
				lit_negative = (c == ilp_pkg::CH_MINUS);
				lit_pos = ilp_pkg::POS_SIGN;
			end else begin
				body_first = (lit_pos == ilp_pkg::POS_NONE || lit_pos == ilp_pkg::POS_SIGN);
				body_second = (lit_pos == ilp_pkg::POS_ONE);
				lit_pos = body_first ? ilp_pkg::POS_ONE : ilp_pkg::POS_MORE;
				if (body_second && lit_first_zero && !fin &&
						(c == ilp_pkg::CH_X || c == ilp_pkg::CH_O || c == ilp_pkg::CH_B)) begin
					lit_radix = (c == ilp_pkg::CH_X) ? ilp_pkg::RDX_HEX :
						((c == ilp_pkg::CH_O) ? ilp_pkg::RDX_OCT : ilp_pkg::RDX_BIN);
					lit_acc = '0;
					lit_prev_digit = 1'b0;
				end else begin
					if (body_first) begin
						lit_first_zero = (c == ilp_pkg::CH_ZERO);
					end
					if (c == ilp_pkg::CH_UNDER) begin
						if (!lit_prev_digit) begin
							lit_error = ilp_pkg::ST_FORMAT;
						end
						lit_prev_digit = 1'b0;
					end else begin
						lit_prev_digit = 1'b1;
						if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) begin
							d = int'(c - ilp_pkg::CH_ZERO);
						end else if (c >= ilp_pkg::CH_LA && c <= ilp_pkg::CH_LF) begin
							d = int'(c - ilp_pkg::CH_LA) + 10;
						end else if (c >= ilp_pkg::CH_UA && c <= ilp_pkg::CH_UF) begin
							d = int'(c - ilp_pkg::CH_UA) + 10;
						end else begin
							d = -1;
						end
						case (lit_radix)
							ilp_pkg::RDX_HEX: rad = 16;
							ilp_pkg::RDX_OCT: rad = 8;
							ilp_pkg::RDX_BIN: rad = 2;
							default: rad = 10;
						endcase
						if (d < 0 || d >= rad) begin
							lit_error = ilp_pkg::ST_NUMBER;
						end else if (lit_acc > (MAX_MAGNITUDE - 64'(d)) / 64'(rad)) begin
							lit_error = ilp_pkg::ST_OVERFLOW;
						end else begin
							lit_acc = lit_acc * 64'(rad) + 64'(d);
						end
					end
				end
			end
		end
		if (fin) begin
			want.status = lit_error;
			if (want.status == ilp_pkg::ST_OK) begin
				if (lit_pos == ilp_pkg::POS_NONE || lit_pos == ilp_pkg::POS_SIGN) begin
					want.status = ilp_pkg::ST_FORMAT;
				end else if (!lit_prev_digit) begin
					want.status = ilp_pkg::ST_NUMBER;
				end
			end
			full = lit_negative ? (64'd0 - lit_acc) : lit_acc;
			want.value = (want.status == ilp_pkg::ST_OK) ? full[ilp_pkg::OUT_WIDTH-1:0] : '0;
			parsed_values = {parsed_values, want};
			clear_literal();
		end
	endtask

	// Presents one character after a random gap, none while no_idle is set, and holds it until the transfer.
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			chr_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		chr_valid <= 1'b1;
		chr_data <= '{ch: c, last: fin};
		@(posedge clk);
		while (!chr_ready) @(posedge clk);
		parse_char(c, fin);
	endtask

	task automatic send_literal();
		foreach (lit_chars[i]) begin
			send_char(lit_chars[i], i == lit_chars.size() - 1);
		end
	endtask

	task automatic send_text(input string s);
		lit_chars.delete();
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i]);
		end
		send_literal();
	endtask

	task automatic test_format_errors();
		send_text("-");
		send_text("_");
		send_text("1_");
		send_text("0b_1");
	endtask

	task automatic test_radix_prefixes();
		send_text("0x");
		send_text("0o8");
		send_text("-0b1");
	endtask

	task automatic test_overflow();
		send_text("0x80000000");
	endtask

	// Mostly well-formed literals with random content; some are boundary values, some corrupted, some noise.
	task automatic test_random_literals();
		int sent;
		int kind;
		int rad;
		int ndig;
		int max_digits;
		int v;
		int pos;
		string s;
		sent = 0;
		while (sent < RANDOM_CHARS) begin
			if ($urandom_range(0, 7) == 0) begin
				no_idle = !no_idle;
			end
			lit_chars.delete();
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
			end else if (kind == 2) begin
				s = boundary_lits[$urandom_range(0, 9)];
				for (int i = 0; i < s.len(); i++) begin
					add_char(s[i]);
				end
			end else begin
				case ($urandom_range(0, 3))
					0: add_char(ilp_pkg::CH_PLUS);
					1: add_char(ilp_pkg::CH_MINUS);
					default: ;
				endcase
				case ($urandom_range(0, 3))
					0: begin
						rad = 16;
						max_digits = 8;
						add_char(ilp_pkg::CH_ZERO);
						add_char(ilp_pkg::CH_X);
					end
					1: begin
						rad = 8;
						max_digits = 11;
						add_char(ilp_pkg::CH_ZERO);
						add_char(ilp_pkg::CH_O);
					end
					2: begin
						rad = 2;
						max_digits = 31;
						add_char(ilp_pkg::CH_ZERO);
						add_char(ilp_pkg::CH_B);
					end
					default: begin
						rad = 10;
						max_digits = 10;
					end
				endcase
				if ($urandom_range(0, 15) == 0) begin
					ndig = 0;
				end else if ($urandom_range(0, 3) == 0) begin
					ndig = max_digits - 1 + $urandom_range(0, 2);
				end else begin
					ndig = $urandom_range(1, 5);
				end
				for (int i = 0; i < ndig; i++) begin
					if (i > 0 && $urandom_range(0, 5) == 0) begin
						add_char(ilp_pkg::CH_UNDER);
					end
					v = $urandom_range(0, rad - 1);
					if (v < 10) begin
						add_char(ilp_pkg::CH_ZERO + 8'(v));
					end else begin
						add_char(($urandom_range(0, 1) ? ilp_pkg::CH_LA : ilp_pkg::CH_UA) +
							8'(v - 10));
					end
				end
				if (lit_chars.size() == 0) begin
					add_char(ilp_pkg::CH_MINUS);
				end
				if (kind == 1) begin
					pos = $urandom_range(0, lit_chars.size() - 1);
					case ($urandom_range(0, 2))
						0: lit_chars[pos] = 8'($urandom_range(0, 255));
						1: lit_chars[pos] = ilp_pkg::CH_UNDER;
						default: add_char(ilp_pkg::CH_UNDER);
					endcase
				end
			end
			sent += lit_chars.size();
			send_literal();
		end
		no_idle = 1'b0;
	endtask

	// Result side: stalls for a random time before each transfer, and not at all while no_idle is set.
	initial begin
		int stall;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			@(negedge clk);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		ilp_pkg::res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (parsed_values.size() == 0) begin
				report_error($sformatf("result with no literal pending: value %0d status %0d",
					res_data.value, res_data.status));
			end else begin
				want = parsed_values.pop_front();
				if (res_data.value !== want.value) begin
					report_error($sformatf("value %0d, expected %0d", res_data.value, want.value));
				end
				if (res_data.status !== want.status) begin
					report_error($sformatf("status %0d, expected %0d", res_data.status,
						want.status));
				end
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((chr_valid && chr_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		chr_valid = 1'b0;
		chr_data = '0;
		clear_literal();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_format_errors();
		test_radix_prefixes();
		test_overflow();
		test_random_literals();
		@(negedge clk);
		chr_valid <= 1'b0;
		while (parsed_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
